// ===== hdl/nat_pkg.sv =====
// Shared types, codes and helpers for the name/address table.
// Used by name_address_table; no dependencies.
package nat_pkg;

  // Default sizing
  localparam int ENTRIES_DEF    = 32;
  localparam int NAME_BYTES_DEF = 8;

  // Address reported by a name lookup that finds nothing
  localparam logic [7:0] ADDR_NONE = 8'hFF;

  // Request codes
  typedef enum logic [2:0] {
    ACT_ADD        = 3'd0,
    ACT_FIND_NAME  = 3'd1,
    ACT_FIND_INDEX = 3'd2,
    ACT_UPD_ADDR   = 3'd3,
    ACT_UPD_INDEX  = 3'd4
  } action_t;

  // Result status codes
  typedef enum logic [1:0] {
    STAT_OK        = 2'd0,
    STAT_NOT_FOUND = 2'd1,
    STAT_FULL      = 2'd2,
    STAT_RANGE     = 2'd3
  } status_t;

  // Sequencer states
  typedef enum logic [1:0] {
    S_IDLE = 2'd0,
    S_SCAN = 2'd1,
    S_DONE = 2'd2
  } state_t;

  // Cut a name at its first zero byte and at nbytes bytes; clear the rest
  function automatic logic [63:0] clean_name(input logic [63:0] raw, input int nbytes);
    logic [63:0] res;
    logic        stop;
    res  = '0;
    stop = 1'b0;
    for (int b = 0; b < 8; b++) begin
      if (!stop && (b < nbytes) && (raw[8*b +: 8] != 8'h00)) begin
        res[8*b +: 8] = raw[8*b +: 8];
      end else begin
        stop = 1'b1;
      end
    end
    return res;
  endfunction

endpackage

// ===== hdl/nat_ram.sv =====
// Generic single-clock RAM: one write port, one read port, registered read.
// Depends on nothing.
module nat_ram #(
  parameter int WIDTH = 72,
  parameter int DEPTH = 32
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic                     re,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  // Write port
  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
  end

  // Registered read port
  always_ff @(posedge clk) begin
    if (re) begin
      rdata <= mem[raddr];
    end
  end

endmodule

// ===== hdl/name_address_table.sv =====
// Name/address table: up to ENTRIES pairs of a zero-padded name and an 8-bit
// address, kept in one RAM and searched one slot per cycle through its single
// read port. A search ends at the first matching slot or after the last stored
// entry; update-by-index and unknown actions skip the search. A finished
// request waits for as long as out_stall holds the previous result in the
// output register. One request is handled at a time; a new request is taken
// while the previous result still waits in the output register.
// Depends on nat_pkg and nat_ram.
module name_address_table #(
  parameter int ENTRIES    = nat_pkg::ENTRIES_DEF,
  parameter int NAME_BYTES = nat_pkg::NAME_BYTES_DEF
) (
  input  logic        clk,
  input  logic        rst_n,
  // request channel
  input  logic        in_valid,
  output logic        in_stall,
  input  logic [2:0]  in_action,
  input  logic [63:0] in_entry_name,
  input  logic [7:0]  in_entry_address,
  input  logic [4:0]  in_entry_index,
  // result channel
  output logic        out_valid,
  input  logic        out_stall,
  output logic [1:0]  out_status,
  output logic [7:0]  out_found_address,
  output logic [4:0]  out_found_index,
  output logic        out_table_empty,
  output logic [5:0]  out_entry_count
);

  localparam int NAME_W = 8 * NAME_BYTES;
  localparam int DATA_W = NAME_W + 8;
  localparam int SLOT_W = $clog2(ENTRIES);
  localparam int CNT_W  = $clog2(ENTRIES + 1);
  localparam int CMP_W  = (CNT_W > 5) ? CNT_W : 5;
  localparam int FI_W   = (SLOT_W > 5) ? SLOT_W : 5;
  localparam int EC_W   = (CNT_W > 6) ? CNT_W : 6;

  // Control state
  nat_pkg::state_t  state_r, state_nxt;
  logic [CNT_W-1:0] count_r, count_nxt;
  logic [CNT_W-1:0] rd_idx_r, rd_idx_nxt;
  logic             rd_pend_r, rd_pend_nxt;
  logic             out_valid_r, out_valid_nxt;

  // Request and working payload
  nat_pkg::action_t  act_r, act_nxt;
  logic [NAME_W-1:0] name_r, name_nxt;
  logic [7:0]        addr_r, addr_nxt;
  logic [SLOT_W-1:0] rd_slot_r, rd_slot_nxt;
  nat_pkg::status_t  res_status_r, res_status_nxt;
  logic [7:0]        res_faddr_r, res_faddr_nxt;
  logic [SLOT_W-1:0] res_fidx_r, res_fidx_nxt;

  // Output payload
  logic [1:0] out_status_r, out_status_nxt;
  logic [7:0] out_faddr_r, out_faddr_nxt;
  logic [4:0] out_fidx_r, out_fidx_nxt;
  logic       out_empty_r, out_empty_nxt;
  logic [5:0] out_count_r, out_count_nxt;

  // RAM ports
  logic              ram_we, ram_re;
  logic [SLOT_W-1:0] ram_waddr, ram_raddr;
  logic [DATA_W-1:0] ram_wdata, ram_rdata;

  // Helpers
  logic [63:0]       in_name_full;
  logic [NAME_W-1:0] in_name;
  logic [CMP_W-1:0]  idx_ext, cnt_ext;
  logic              idx_bad;
  logic              in_xfer, out_free;
  logic              slot_match, hit, miss, full;
  logic [FI_W-1:0]   fidx_ext;
  logic [EC_W-1:0]   count_ext;

  assign in_name_full = nat_pkg::clean_name(in_entry_name, NAME_BYTES);
  assign in_name      = in_name_full[NAME_W-1:0];
  assign idx_ext      = CMP_W'(in_entry_index);
  assign cnt_ext      = CMP_W'(count_r);
  assign idx_bad      = (idx_ext >= cnt_ext);
  assign in_stall     = (state_r != nat_pkg::S_IDLE);
  assign in_xfer      = in_valid && !in_stall;
  assign out_free     = !out_valid_r || !out_stall;
  assign full         = (count_r == CNT_W'(ENTRIES));
  assign fidx_ext     = FI_W'(res_fidx_r);
  assign count_ext    = EC_W'(count_r);

  // Compare the slot read last cycle; name lookups match names, others addresses
  always_comb begin
    if (act_r == nat_pkg::ACT_FIND_NAME) begin
      slot_match = (ram_rdata[NAME_W-1:0] == name_r);
    end else begin
      slot_match = (ram_rdata[DATA_W-1:NAME_W] == addr_r);
    end
  end
  assign hit  = rd_pend_r && slot_match;
  assign miss = !rd_pend_r && (rd_idx_r >= count_r);

  nat_ram #(
    .WIDTH (DATA_W),
    .DEPTH (ENTRIES)
  ) u_ram (
    .clk   (clk),
    .we    (ram_we),
    .waddr (ram_waddr),
    .wdata (ram_wdata),
    .re    (ram_re),
    .raddr (ram_raddr),
    .rdata (ram_rdata)
  );

  // Next state, RAM control and result bookkeeping
  always_comb begin
    state_nxt      = state_r;
    count_nxt      = count_r;
    rd_idx_nxt     = rd_idx_r;
    rd_pend_nxt    = 1'b0;
    rd_slot_nxt    = rd_slot_r;
    out_valid_nxt  = out_valid_r;
    act_nxt        = act_r;
    name_nxt       = name_r;
    addr_nxt       = addr_r;
    res_status_nxt = res_status_r;
    res_faddr_nxt  = res_faddr_r;
    res_fidx_nxt   = res_fidx_r;
    out_status_nxt = out_status_r;
    out_faddr_nxt  = out_faddr_r;
    out_fidx_nxt   = out_fidx_r;
    out_empty_nxt  = out_empty_r;
    out_count_nxt  = out_count_r;
    ram_we         = 1'b0;
    ram_waddr      = rd_slot_r;
    ram_wdata      = {addr_r, name_r};
    ram_re         = 1'b0;
    ram_raddr      = rd_idx_r[SLOT_W-1:0];

    // result register drains independently of the sequencer
    if (out_valid_r && !out_stall) begin
      out_valid_nxt = 1'b0;
    end

    unique case (state_r)
      nat_pkg::S_IDLE: begin
        if (in_xfer) begin
          act_nxt        = nat_pkg::action_t'(in_action);
          name_nxt       = in_name;
          addr_nxt       = in_entry_address;
          res_status_nxt = nat_pkg::STAT_OK;
          res_faddr_nxt  = '0;
          res_fidx_nxt   = '0;
          rd_idx_nxt     = '0;
          unique case (nat_pkg::action_t'(in_action)) inside
            nat_pkg::ACT_ADD, nat_pkg::ACT_FIND_NAME,
            nat_pkg::ACT_FIND_INDEX, nat_pkg::ACT_UPD_ADDR: begin
              state_nxt = nat_pkg::S_SCAN;
            end
            nat_pkg::ACT_UPD_INDEX: begin
              // slot known up front: write straight away
              if (idx_bad) begin
                res_status_nxt = nat_pkg::STAT_RANGE;
              end else begin
                ram_we    = 1'b1;
                ram_waddr = SLOT_W'(in_entry_index);
                ram_wdata = {in_entry_address, in_name};
              end
              state_nxt = nat_pkg::S_DONE;
            end
            default: begin
              state_nxt = nat_pkg::S_DONE;
            end
          endcase
        end
      end

      nat_pkg::S_SCAN: begin
        // read one slot ahead of the compare
        if (rd_idx_r < count_r) begin
          ram_re      = 1'b1;
          rd_pend_nxt = 1'b1;
          rd_slot_nxt = rd_idx_r[SLOT_W-1:0];
          rd_idx_nxt  = rd_idx_r + 1'b1;
        end
        if (hit || miss) begin
          rd_pend_nxt = 1'b0;
          state_nxt   = nat_pkg::S_DONE;
          case (act_r)
            nat_pkg::ACT_ADD: begin
              if (hit) begin
                ram_we = 1'b1;
              end else if (full) begin
                res_status_nxt = nat_pkg::STAT_FULL;
              end else begin
                ram_we    = 1'b1;
                ram_waddr = count_r[SLOT_W-1:0];
                count_nxt = count_r + 1'b1;
              end
            end
            nat_pkg::ACT_FIND_NAME: begin
              if (hit) begin
                res_faddr_nxt = ram_rdata[DATA_W-1:NAME_W];
              end else begin
                res_faddr_nxt  = nat_pkg::ADDR_NONE;
                res_status_nxt = nat_pkg::STAT_NOT_FOUND;
              end
            end
            nat_pkg::ACT_FIND_INDEX: begin
              if (hit) begin
                res_fidx_nxt = rd_slot_r;
              end else begin
                res_status_nxt = nat_pkg::STAT_NOT_FOUND;
              end
            end
            default: begin
              // update by address
              if (hit) begin
                ram_we = 1'b1;
              end else begin
                res_status_nxt = nat_pkg::STAT_NOT_FOUND;
              end
            end
          endcase
        end
      end

      nat_pkg::S_DONE: begin
        // hand the result over once the output register is free
        if (out_free) begin
          out_valid_nxt  = 1'b1;
          out_status_nxt = res_status_r;
          out_faddr_nxt  = res_faddr_r;
          out_fidx_nxt   = fidx_ext[4:0];
          out_empty_nxt  = (count_r == '0);
          out_count_nxt  = count_ext[5:0];
          state_nxt      = nat_pkg::S_IDLE;
        end
      end

      default: begin
        state_nxt = nat_pkg::S_IDLE;
      end
    endcase
  end

  // Control registers
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= nat_pkg::S_IDLE;
      count_r     <= '0;
      rd_idx_r    <= '0;
      rd_pend_r   <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      count_r     <= count_nxt;
      rd_idx_r    <= rd_idx_nxt;
      rd_pend_r   <= rd_pend_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  // Payload registers
  always_ff @(posedge clk) begin
    act_r        <= act_nxt;
    name_r       <= name_nxt;
    addr_r       <= addr_nxt;
    rd_slot_r    <= rd_slot_nxt;
    res_status_r <= res_status_nxt;
    res_faddr_r  <= res_faddr_nxt;
    res_fidx_r   <= res_fidx_nxt;
    out_status_r <= out_status_nxt;
    out_faddr_r  <= out_faddr_nxt;
    out_fidx_r   <= out_fidx_nxt;
    out_empty_r  <= out_empty_nxt;
    out_count_r  <= out_count_nxt;
  end

  assign out_valid         = out_valid_r;
  assign out_status        = out_status_r;
  assign out_found_address = out_faddr_r;
  assign out_found_index   = out_fidx_r;
  assign out_table_empty   = out_empty_r;
  assign out_entry_count   = out_count_r;

  // Checks
  a_count_bound: assert property (@(posedge clk) disable iff (!rst_n)
    count_r <= CNT_W'(ENTRIES))
    else $error("entry count above table size");

  a_count_step: assert property (@(posedge clk) disable iff (!rst_n)
    ($past(rst_n) && (count_r != $past(count_r))) |->
      ($past(state_r) == nat_pkg::S_SCAN && count_r == $past(count_r) + 1'b1))
    else $error("entry count changed outside an append");

  a_result_from_done: assert property (@(posedge clk) disable iff (!rst_n)
    ($past(rst_n) && $rose(out_valid_r)) |-> ($past(state_r) == nat_pkg::S_DONE))
    else $error("result raised without a finished request");

  a_read_in_range: assert property (@(posedge clk) disable iff (!rst_n)
    rd_pend_r |-> (CNT_W'(rd_slot_r) < count_r && state_r == nat_pkg::S_SCAN))
    else $error("compare of a slot beyond the count");

endmodule
